### src/b2bcd_pkg.sv
package b2bcd_pkg;

	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned DIGIT_W        = 4;
	localparam int unsigned INDEX_W        = 3;
	localparam int unsigned COUNT_W        = 4;
	localparam int unsigned MAX_DIGITS_DEF = 8;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

### src/b2bcd_value_if.sv
interface b2bcd_value_if;
	import b2bcd_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### src/b2bcd_digit_if.sv
interface b2bcd_digit_if;
	import b2bcd_pkg::*;

	logic               valid;
	logic               ready;
	digit_t             bcd_digit;
	logic [INDEX_W-1:0] display_index;
	logic               last_digit;

	modport source (output valid, output bcd_digit, output display_index, output last_digit,
		input ready);
	modport sink (input valid, input bcd_digit, input display_index, input last_digit,
		output ready);
endinterface

### src/b2bcd_cfg_if.sv
interface b2bcd_cfg_if;
	import b2bcd_pkg::*;

	logic   valid;
	logic   ready;
	count_t digit_count;

	modport source (output valid, output digit_count, input ready);
	modport sink (input valid, input digit_count, output ready);
endinterface

### src/b2bcd_cell.sv
module b2bcd_cell #(
	parameter int unsigned MAX_DIGITS = b2bcd_pkg::MAX_DIGITS_DEF,
	parameter int unsigned POS        = 0
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        up_valid,
	input  b2bcd_pkg::value_t                           up_rest,
	input  logic [MAX_DIGITS-1:0][b2bcd_pkg::DIGIT_W-1:0] up_digits,
	output logic                                        dn_valid,
	output b2bcd_pkg::value_t                           dn_rest,
	output logic [MAX_DIGITS-1:0][b2bcd_pkg::DIGIT_W-1:0] dn_digits
);
	import b2bcd_pkg::*;

	logic [2*VALUE_W-1:0] prod;
	value_t               quot;
	value_t               rem_full;
	logic                 valid_q;
	value_t               rest_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_next;

	// divide by ten through the reciprocal, remainder by shift-and-add back
	assign prod     = {{VALUE_W{1'b0}}, up_rest} * {{VALUE_W{1'b0}}, RECIP_TEN};
	assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
	assign rem_full = up_rest - (quot << 3) - (quot << 1);

	always_comb begin
		digits_next      = up_digits;
		digits_next[POS] = rem_full[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rest_q   <= quot;
			digits_q <= digits_next;
		end
	end

	assign dn_valid  = valid_q;
	assign dn_rest   = rest_q;
	assign dn_digits = digits_q;

endmodule

### src/b2bcd_serializer.sv
module b2bcd_serializer #(
	parameter int unsigned MAX_DIGITS = b2bcd_pkg::MAX_DIGITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  b2bcd_pkg::count_t                           count,
	input  logic                                        tail_valid,
	input  logic [MAX_DIGITS-1:0][b2bcd_pkg::DIGIT_W-1:0] tail_digits,
	output logic                                        take,
	b2bcd_digit_if.source                               digits
);
	import b2bcd_pkg::*;

	localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic                               busy_q;
	count_t                             idx_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] buf_q;
	logic                               last;
	count_t                             idx_next;

	assign idx_next = idx_q + count_t'(1);
	assign last     = (idx_next == count);
	assign take     = tail_valid && (!busy_q || (digits.ready && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			// a zero digit count swallows the value
			busy_q <= (count != '0);
			idx_q  <= '0;
		end else if (busy_q && digits.ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= tail_digits;
		end
	end

	assign digits.valid         = busy_q;
	assign digits.bcd_digit     = buf_q[idx_q[IDX_W-1:0]];
	assign digits.display_index = idx_q[INDEX_W-1:0];
	assign digits.last_digit    = last;

endmodule

### src/binary_to_bcd_digit_strobe.sv
// channel  dir  payload                                        beat
// cfg      in   digit_count[3:0]                               one register write
// bin      in   value[31:0]                                    one binary value
// digits   out  bcd_digit[3:0] display_index[2:0] last_digit   one digit, lsd first
//
// a value passes a row of MAX_DIGITS divide-by-ten cells, one cell per cycle
// while the row advances, then the serializer buffer before its first digit shows
// the digit port then moves one digit per cycle while digits.ready is high: a value
// gives it min(digit_count, MAX_DIGITS) digits, a zero count value none
// the cell row advances only when its tail is empty or handed to the digit port
// reset clears the valid bits and sets digit_count to 3
module binary_to_bcd_digit_strobe #(
	parameter int unsigned MAX_DIGITS = b2bcd_pkg::MAX_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	b2bcd_cfg_if.sink     cfg,
	b2bcd_value_if.sink   bin,
	b2bcd_digit_if.source digits
);
	import b2bcd_pkg::*;

	count_t count_q;
	count_t count_sat;
	logic   adv;
	logic   take;

	logic                               cell_valid  [MAX_DIGITS+1];
	value_t                             cell_rest   [MAX_DIGITS+1];
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] cell_digits [MAX_DIGITS+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.digit_count;
		end
	end

	assign count_sat = (count_q > count_t'(MAX_DIGITS)) ? count_t'(MAX_DIGITS) : count_q;

	assign adv       = !cell_valid[MAX_DIGITS] || take;
	assign bin.ready = adv;

	assign cell_valid[0]  = bin.valid;
	assign cell_rest[0]   = bin.value;
	assign cell_digits[0] = '0;

	for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
		b2bcd_cell #(
			.MAX_DIGITS(MAX_DIGITS),
			.POS       (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.up_valid (cell_valid[k]),
			.up_rest  (cell_rest[k]),
			.up_digits(cell_digits[k]),
			.dn_valid (cell_valid[k+1]),
			.dn_rest  (cell_rest[k+1]),
			.dn_digits(cell_digits[k+1])
		);
	end

	b2bcd_serializer #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.count      (count_sat),
		.tail_valid (cell_valid[MAX_DIGITS]),
		.tail_digits(cell_digits[MAX_DIGITS]),
		.take       (take),
		.digits     (digits)
	);

endmodule

### test/b2bcd_digit_checker.sv
`timescale 1ns / 100ps

module b2bcd_digit_checker #(
	parameter int unsigned MAX_DIGITS = b2bcd_pkg::MAX_DIGITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	b2bcd_cfg_if   cfg,
	b2bcd_value_if bin,
	b2bcd_digit_if digits,
	output int     mismatches,
	output int     digits_owed
);
	import b2bcd_pkg::*;

	typedef struct packed {
		digit_t             bcd;
		logic [INDEX_W-1:0] index;
		logic               last;
	} digit_beat_t;

	count_t      shown_count;
	digit_beat_t expected_digits[$];

	initial mismatches = 0;

	task automatic note_mismatch(input string what, input digit_beat_t want,
		input digit_beat_t got);
		if (mismatches < 10) begin
			$display("%0t: %s: expected digit %0d index %0d last %0d, got digit %0d index %0d last %0d",
				$realtime, what, want.bcd, want.index, want.last, got.bcd, got.index, got.last);
		end
		mismatches++;
	endtask

	// one expected beat per shown digit, least significant first
	task automatic split_to_digits(input value_t v);
		value_t      rest;
		int unsigned n;
		int unsigned k;
		digit_beat_t beat;
		rest = v;
		n = (shown_count > MAX_DIGITS) ? MAX_DIGITS : shown_count;
		for (k = 0; k < n; k++) begin
			beat.bcd = digit_t'(rest % 10);
			beat.index = INDEX_W'(k);
			beat.last = (k + 1 == n);
			expected_digits.push_back(beat);
			rest = rest / 10;
		end
	endtask

	task automatic check_digit(input digit_beat_t got);
		digit_beat_t want;
		if (expected_digits.size() == 0) begin
			note_mismatch("digit beat with none expected", '0, got);
		end else begin
			want = expected_digits.pop_front();
			if (got !== want) begin
				note_mismatch("digit mismatch", want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_count = COUNT_RESET;
			expected_digits.delete();
			digits_owed = 0;
		end else begin
			if (digits.valid && digits.ready) begin
				check_digit('{bcd: digits.bcd_digit, index: digits.display_index,
					last: digits.last_digit});
			end
			if (cfg.valid && cfg.ready) begin
				shown_count = cfg.digit_count;
			end
			if (bin.valid && bin.ready) begin
				split_to_digits(bin.value);
			end
			digits_owed = expected_digits.size();
		end
	end

endmodule

### test/tb_binary_to_bcd_digit_strobe.sv
`timescale 1ns / 100ps

module tb_binary_to_bcd_digit_strobe;
	import b2bcd_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 4000;
	localparam int unsigned SETTLE_CYCLES   = 3 * MAX_DIGITS_DEF;
	localparam int unsigned PHASES          = 12;
	localparam int unsigned ITEMS_PER_PHASE = 23;

	typedef enum int unsigned {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// extremes, saturation and zero count among the settings
	localparam count_t PHASE_COUNT [PHASES] = '{
		4'd5, 4'd8, 4'd1, 4'd15, 4'd3, 4'd9, 4'd7, 4'd0, 4'd6, 4'd2, 4'd4, 4'd8
	};

	logic        clk;
	logic        arst_n;
	int          mismatches;
	int          digits_owed;
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned quiet_cycles;

	b2bcd_cfg_if   cfg_ch ();
	b2bcd_value_if bin_ch ();
	b2bcd_digit_if dig_ch ();

	binary_to_bcd_digit_strobe dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.bin    (bin_ch),
		.digits (dig_ch)
	);

	b2bcd_digit_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.bin         (bin_ch),
		.digits      (dig_ch),
		.mismatches  (mismatches),
		.digits_owed (digits_owed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		dig_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
	end

	// counts cycles without any beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (bin_ch.valid && bin_ch.ready) || (dig_ch.valid && dig_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic value_t random_value();
		value_t p;
		p = 1;
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(999);
			2: begin
				// just below or at a power of ten
				repeat ($urandom_range(1, 9)) p = p * 10;
				return $urandom_range(1) ? p : p - 1;
			end
			default: return $urandom_range(99999999);
		endcase
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct = 64;
				rx_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct = 0;
				rx_stall_pct = 64;
			end
			default: begin
				tx_idle_pct = 20;
				rx_stall_pct = 20;
			end
		endcase
	endtask

	// valid stays high into the next beat when no idle cycle is drawn
	task automatic send_value(input value_t v);
		while ($urandom_range(99) < tx_idle_pct) begin
			bin_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bin_ch.valid <= 1'b1;
		bin_ch.value <= v;
		do @(posedge clk); while (!bin_ch.ready);
	endtask

	// zero count values leave nothing owed, so let the cell row empty too
	task automatic wait_drained();
		bin_ch.valid <= 1'b0;
		do @(negedge clk); while (digits_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_digit_count(input count_t c);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.digit_count <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.digit_count = '0;
		bin_ch.valid = 1'b0;
		bin_ch.value = '0;
		dig_ch.ready = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset count of three digits
		send_value(32'd0);
		send_value(32'd999);
		send_value(32'd1000);
		send_value(32'hFFFF_FFFF);
		send_value(32'd7);

		// all eight latches, leading zeros shown as zero
		write_digit_count(4'd8);
		send_value(32'd0);
		send_value(32'd99999999);
		send_value(32'd100000000);
		send_value(32'hFFFF_FFFF);
		send_value(32'd12345678);
		send_value(32'd5);

		// zero count shows nothing
		write_digit_count(4'd0);
		send_value(32'hFFFF_FFFF);
		send_value(32'd42);

		// count above eight saturates
		write_digit_count(4'd15);
		send_value(32'hFFFF_FFFF);
		send_value(32'd1);

		write_digit_count(4'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'h8000_0000);

		for (int unsigned p = 0; p < PHASES; p++) begin
			set_idling(idle_mode_t'(p % 4));
			write_digit_count(PHASE_COUNT[p]);
			repeat (ITEMS_PER_PHASE) send_value(random_value());
		end

		wait_drained();
		if (mismatches == 0 && digits_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### binary_to_bcd_digit_strobe.f
src/b2bcd_pkg.sv
src/b2bcd_value_if.sv
src/b2bcd_digit_if.sv
src/b2bcd_cfg_if.sv
src/b2bcd_cell.sv
src/b2bcd_serializer.sv
src/binary_to_bcd_digit_strobe.sv
test/b2bcd_digit_checker.sv
test/tb_binary_to_bcd_digit_strobe.sv
